/* src/steer_wheel_inverse_kinematics_assert.svh */
// Assertion macros shared by the steer wheel inverse kinematics RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STEER_WHEEL_INVERSE_KINEMATICS_ASSERT_SVH
`define STEER_WHEEL_INVERSE_KINEMATICS_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SWIK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SWIK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/swik_pkg.sv */
// Shared types, constants and the arctangent table for the steer wheel kinematics.
// Used by swik_cfg, swik_cordic and steer_wheel_inverse_kinematics; no dependencies.
`default_nettype none

package swik_pkg;

    // Datapath widths: CORDIC coordinates, angle accumulator (Q2.29), magnitude.
    localparam int CW = 36;
    localparam int ZW = 34;
    localparam int MW = 34;

    localparam logic signed [ZW-1:0] PI_Q29       = 34'sd1686629713;
    localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
    localparam logic [18:0]          HOLD_LIMIT   = 19'd12867;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_OFFSET_X    = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [2:0] REG_SPEED_SCALE = 3'd2;
    localparam logic [2:0] REG_ANGLE_SCALE = 3'd3;
    localparam logic [2:0] REG_STOP_THR    = 3'd4;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_SPIN  = 2'd1,
        MODE_DRIVE = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [23:0]        speed_scale;
        logic [23:0]        angle_scale;
        logic [11:0]        stop_threshold;
    } cfg_t;

    // Request data carried alongside the offset CORDIC.
    typedef struct packed {
        logic signed [15:0] v;
        logic signed [15:0] w;
        logic [15:0]        aw;
        logic signed [15:0] cur;
        mode_t              mode;
        logic               clamp;
    } side_a_t;

    // Request data carried alongside the wheel velocity CORDIC.
    typedef struct packed {
        mode_t                 mode;
        logic                  neg;
        logic signed [15:0]    cur;
        logic [MW-1:0]         spin_mag;
        logic signed [ZW-1:0]  spin_ang;
    } side_b_t;

    // atan(2^-i) in Q2.29.
    function automatic logic signed [ZW-1:0] atan_q29(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:       r = 34'sd421657428;
            1:       r = 34'sd248918915;
            2:       r = 34'sd131521918;
            3:       r = 34'sd66762579;
            4:       r = 34'sd33510843;
            5:       r = 34'sd16771755;
            6:       r = 34'sd8387925;
            7:       r = 34'sd4194219;
            8:       r = 34'sd2097141;
            9:       r = 34'sd1048575;
            10:      r = 34'sd524288;
            11:      r = 34'sd262144;
            12:      r = 34'sd131072;
            13:      r = 34'sd65536;
            14:      r = 34'sd32768;
            15:      r = 34'sd16384;
            16:      r = 34'sd8192;
            17:      r = 34'sd4096;
            18:      r = 34'sd2048;
            19:      r = 34'sd1024;
            20:      r = 34'sd512;
            21:      r = 34'sd256;
            22:      r = 34'sd128;
            23:      r = 34'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/swik_cfg.sv */
// Configuration register file behind the APB-style port.
// Depends on swik_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module swik_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output swik_pkg::cfg_t     cfg
);
    import swik_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_y       <= '0;
            cfg_reg.speed_scale    <= '0;
            cfg_reg.angle_scale    <= '0;
            cfg_reg.stop_threshold <= 12'd4;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_OFFSET_X:    cfg_reg.offset_x       <= pwdata[15:0];
                REG_OFFSET_Y:    cfg_reg.offset_y       <= pwdata[15:0];
                REG_SPEED_SCALE: cfg_reg.speed_scale    <= pwdata[23:0];
                REG_ANGLE_SCALE: cfg_reg.angle_scale    <= pwdata[23:0];
                REG_STOP_THR:    cfg_reg.stop_threshold <= pwdata[11:0];
                default:         ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_OFFSET_X:    prdata = {16'd0, cfg_reg.offset_x};
            REG_OFFSET_Y:    prdata = {16'd0, cfg_reg.offset_y};
            REG_SPEED_SCALE: prdata = {8'd0, cfg_reg.speed_scale};
            REG_ANGLE_SCALE: prdata = {8'd0, cfg_reg.angle_scale};
            REG_STOP_THR:    prdata = {20'd0, cfg_reg.stop_threshold};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/swik_cordic.sv */
// Pipelined vectoring CORDIC: one stage per iteration plus quadrant fold and gain stages.
// Depends on swik_pkg for widths, the arctangent table and the gain constant.
`default_nettype none

module swik_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [swik_pkg::CW-1:0] in_x,
    input  wire logic signed [swik_pkg::CW-1:0] in_y,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [swik_pkg::MW-1:0]            out_mag,
    output logic signed [swik_pkg::ZW-1:0]     out_ang,
    output logic [SIDE_W-1:0]                  out_side
);
    import swik_pkg::*;

    logic                 valid_reg [0:STAGES];
    logic signed [CW-1:0] x_reg     [0:STAGES];
    logic signed [CW-1:0] y_reg     [0:STAGES];
    logic signed [ZW-1:0] z_reg     [0:STAGES];
    logic                 zero_reg  [0:STAGES];
    logic [SIDE_W-1:0]    side_reg  [0:STAGES];

    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;
    logic                 zero_next;

    logic                 out_valid_reg;
    logic [MW-1:0]        mag_reg;
    logic signed [ZW-1:0] ang_reg;
    logic [SIDE_W-1:0]    oside_reg;
    logic [CW-2:0]        x_end;
    logic [CW+29:0]       gain_prod;

    // Fold the left half plane onto the right, starting the angle at +-pi.
    always_comb
    begin
        zero_next = (in_x == '0) && (in_y == '0);
        if (in_x < 0)
        begin
            x_next = -in_x;
            y_next = -in_y;
            z_next = (in_y >= 0) ? PI_Q29 : -PI_Q29;
        end
        else
        begin
            x_next = in_x;
            y_next = in_y;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= zero_next;
            side_reg[0] <= in_side;
        end
    end

    // One micro-rotation per stage, driving y towards zero.
    for (genvar k = 0; k < STAGES; k++)
    begin : g_iter
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[k] >= 0)
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_q29(k);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_q29(k);
                end
                zero_reg[k+1] <= zero_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Remove the CORDIC gain with rounding; a zero vector reports angle zero.
    assign x_end     = x_reg[STAGES][CW-2:0];
    assign gain_prod = (CW+30)'(x_end) * (CW+30)'(INV_GAIN_Q30) + ((CW+30)'(1) << 29);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= gain_prod[30 +: MW];
            ang_reg   <= zero_reg[STAGES] ? '0 : z_reg[STAGES];
            oside_reg <= side_reg[STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mag   = mag_reg;
    assign out_ang   = ang_reg;
    assign out_side  = oside_reg;

endmodule

`default_nettype wire

/* src/steer_wheel_inverse_kinematics.sv */
// Path: a request accepted into p0 passes p1, p2, the offset CORDIC, q1, the wheel
// CORDIC, r1, r2 and r3 before the output register shows its result on res_valid.
// Throughput: one request per cycle; two CORDIC pipelines in series set the depth,
// and the whole pipeline holds while a finished result is stalled.
// Reset: rst_n clears all valid bits and loads the register reset values.
// Depends on swik_pkg, swik_cfg, swik_cordic and the assertion macro header.
`default_nettype none

module steer_wheel_inverse_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire logic signed [15:0] linear_velocity,
    input  wire logic signed [15:0] yaw_rate,
    input  wire logic signed [15:0] current_steer_angle,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [31:0]      speed_command,
    output logic signed [31:0]      steer_command,
    output logic                    speed_held,
    output logic [1:0]              drive_mode
);
    import swik_pkg::*;

    localparam int SA_W = $bits(side_a_t);
    localparam int SB_W = $bits(side_b_t);

    cfg_t cfg;
    logic adv;

    assign pready    = 1'b1;
    assign adv       = !(res_valid && res_stall);
    assign cmd_stall = !adv;

    swik_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Squared offset norm follows the configuration every cycle.
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic [31:0]        norm2_reg;

    assign sq_x = 32'(cfg.offset_x) * 32'(cfg.offset_x);
    assign sq_y = 32'(cfg.offset_y) * 32'(cfg.offset_y);

    always_ff @(posedge clk)
    begin
        norm2_reg <= 32'(sq_x) + 32'(sq_y);
    end

    // Stage p0: input request register.
    logic               p0_valid_reg;
    logic signed [15:0] p0_v_reg;
    logic signed [15:0] p0_w_reg;
    logic signed [15:0] p0_cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_v_reg   <= linear_velocity;
            p0_w_reg   <= yaw_rate;
            p0_cur_reg <= current_steer_angle;
        end
    end

    // Stage p1: magnitudes, mode decision and squares.
    logic [15:0] av;
    logic [15:0] aw;
    mode_t       mode_p0;

    assign av = p0_v_reg[15] ? (~p0_v_reg + 16'd1) : p0_v_reg;
    assign aw = p0_w_reg[15] ? (~p0_w_reg + 16'd1) : p0_w_reg;

    always_comb
    begin
        if (av < {4'd0, cfg.stop_threshold} && aw < {4'd0, cfg.stop_threshold})
        begin
            mode_p0 = MODE_STOP;
        end
        else if (av < {4'd0, cfg.stop_threshold})
        begin
            mode_p0 = MODE_SPIN;
        end
        else
        begin
            mode_p0 = MODE_DRIVE;
        end
    end

    logic               p1_valid_reg;
    logic signed [15:0] p1_v_reg;
    logic signed [15:0] p1_w_reg;
    logic signed [15:0] p1_cur_reg;
    logic [15:0]        p1_aw_reg;
    mode_t              p1_mode_reg;
    logic [31:0]        p1_av2_reg;
    logic [31:0]        p1_aw2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_v_reg    <= p0_v_reg;
            p1_w_reg    <= p0_w_reg;
            p1_cur_reg  <= p0_cur_reg;
            p1_aw_reg   <= aw;
            p1_mode_reg <= mode_p0;
            p1_av2_reg  <= 32'(av) * 32'(av);
            p1_aw2_reg  <= 32'(aw) * 32'(aw);
        end
    end

    // Stage p2: right-hand side of the turning radius clamp test.
    logic               p2_valid_reg;
    logic signed [15:0] p2_v_reg;
    logic signed [15:0] p2_w_reg;
    logic signed [15:0] p2_cur_reg;
    logic [15:0]        p2_aw_reg;
    mode_t              p2_mode_reg;
    logic [31:0]        p2_av2_reg;
    logic [63:0]        p2_rhs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_v_reg    <= p1_v_reg;
            p2_w_reg    <= p1_w_reg;
            p2_cur_reg  <= p1_cur_reg;
            p2_aw_reg   <= p1_aw_reg;
            p2_mode_reg <= p1_mode_reg;
            p2_av2_reg  <= p1_av2_reg;
            p2_rhs_reg  <= 64'(p1_aw2_reg) * 64'(norm2_reg);
        end
    end

    // Offset vector into the first CORDIC: rotated by a quarter turn in spin.
    logic signed [CW-1:0] pxs;
    logic signed [CW-1:0] pys;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    side_a_t              sa_in;

    assign pxs = CW'(cfg.offset_x) <<< 12;
    assign pys = CW'(cfg.offset_y) <<< 12;

    always_comb
    begin
        if (p2_mode_reg == MODE_SPIN)
        begin
            a_x = -pys;
            a_y = pxs;
        end
        else
        begin
            a_x = pxs;
            a_y = pys;
        end
        sa_in.v     = p2_v_reg;
        sa_in.w     = p2_w_reg;
        sa_in.aw    = p2_aw_reg;
        sa_in.cur   = p2_cur_reg;
        sa_in.mode  = p2_mode_reg;
        sa_in.clamp = {8'd0, p2_av2_reg, 24'd0} < p2_rhs_reg;
    end

    logic                 a_valid;
    logic [MW-1:0]        a_mag;
    logic signed [ZW-1:0] a_ang;
    logic [SA_W-1:0]      a_side;
    side_a_t              sa_out;

    swik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SA_W)
    ) u_cordic_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p2_valid_reg),
        .in_x      (a_x),
        .in_y      (a_y),
        .in_side   (sa_in),
        .out_valid (a_valid),
        .out_mag   (a_mag),
        .out_ang   (a_ang),
        .out_side  (a_side)
    );

    assign sa_out = side_a_t'(a_side);

    // Stage q1: |w| * |p|.
    logic                 q1_valid_reg;
    logic [MW+15:0]       q1_prod_reg;
    logic signed [ZW-1:0] q1_ang_reg;
    side_a_t              q1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q1_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_prod_reg <= (MW+16)'(a_mag) * (MW+16)'(sa_out.aw);
            q1_ang_reg  <= a_ang;
            q1_side_reg <= sa_out;
        end
    end

    // Wheel velocity at the offset, folded into the right half plane.
    logic [MW+15:0]       prod_rnd;
    logic [MW-1:0]        base_mag;
    logic signed [CW-1:0] bm_s;
    logic signed [CW-1:0] base;
    logic signed [CW-1:0] wpx;
    logic signed [CW-1:0] wpy;
    logic signed [CW-1:0] wx;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic                 fold;
    side_b_t              sb_in;

    assign prod_rnd = q1_prod_reg + (MW+16)'(2048);
    assign base_mag = prod_rnd[12 +: MW];
    assign bm_s     = $signed(CW'(base_mag));
    assign wpx      = CW'(q1_side_reg.w) * CW'(cfg.offset_x);
    assign wpy      = CW'(q1_side_reg.w) * CW'(cfg.offset_y);

    always_comb
    begin
        if (q1_side_reg.clamp)
        begin
            base = q1_side_reg.v[15] ? -bm_s : bm_s;
        end
        else
        begin
            base = CW'(q1_side_reg.v) <<< 12;
        end
        wx   = base - wpy;
        fold = wx < 0;
        b_x  = fold ? -wx : wx;
        b_y  = fold ? -wpx : wpx;

        sb_in.mode     = q1_side_reg.mode;
        sb_in.cur      = q1_side_reg.cur;
        sb_in.spin_mag = base_mag;
        sb_in.spin_ang = q1_ang_reg;
        case (q1_side_reg.mode)
            MODE_SPIN:  sb_in.neg = q1_side_reg.w[15];
            MODE_DRIVE: sb_in.neg = fold;
            default:    sb_in.neg = 1'b0;
        endcase
    end

    logic                 b_valid;
    logic [MW-1:0]        b_mag;
    logic signed [ZW-1:0] b_ang;
    logic [SB_W-1:0]      b_side;
    side_b_t              sb_out;

    swik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SB_W)
    ) u_cordic_wheel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (q1_valid_reg),
        .in_x      (b_x),
        .in_y      (b_y),
        .in_side   (sb_in),
        .out_valid (b_valid),
        .out_mag   (b_mag),
        .out_ang   (b_ang),
        .out_side  (b_side)
    );

    assign sb_out = side_b_t'(b_side);

    // Stage r1: pick the result for the mode and round the angle to Q2.13.
    logic [MW-1:0]        mag_sel;
    logic signed [ZW-1:0] a29;
    logic [ZW-1:0]        a29_abs;
    logic [ZW-1:0]        a29_rnd;
    logic [ZW-17:0]       a13_mag;
    logic signed [ZW-17:0] a13;

    always_comb
    begin
        case (sb_out.mode)
            MODE_SPIN:
            begin
                mag_sel = sb_out.spin_mag;
                a29     = sb_out.spin_ang;
            end
            MODE_DRIVE:
            begin
                mag_sel = b_mag;
                a29     = b_ang;
            end
            default:
            begin
                mag_sel = '0;
                a29     = '0;
            end
        endcase
        a29_abs = a29[ZW-1] ? ZW'(-a29) : ZW'(a29);
        a29_rnd = a29_abs + ZW'(32768);
        a13_mag = a29_rnd[ZW-1:16];
        a13     = a29[ZW-1] ? -$signed(a13_mag) : $signed(a13_mag);
    end

    logic                  r1_valid_reg;
    logic [MW-1:0]         r1_mag_reg;
    logic signed [ZW-17:0] r1_a13_reg;
    logic                  r1_neg_reg;
    logic signed [15:0]    r1_cur_reg;
    mode_t                 r1_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_mag_reg  <= mag_sel;
            r1_a13_reg  <= a13;
            r1_neg_reg  <= sb_out.neg;
            r1_cur_reg  <= sb_out.cur;
            r1_mode_reg <= sb_out.mode;
        end
    end

    // Stage r2: hold the speed while the wheel is more than a quarter turn off.
    logic signed [18:0] diff;
    logic [18:0]        diff_abs;
    logic               held;

    assign diff     = 19'(r1_cur_reg) - 19'(r1_a13_reg);
    assign diff_abs = diff[18] ? 19'(-diff) : 19'(diff);
    assign held     = (r1_mode_reg != MODE_STOP) && (diff_abs > HOLD_LIMIT);

    logic                  r2_valid_reg;
    logic [MW-1:0]         r2_mag_reg;
    logic signed [ZW-17:0] r2_a13_reg;
    logic                  r2_neg_reg;
    logic                  r2_held_reg;
    mode_t                 r2_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r2_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_mag_reg  <= held ? '0 : r1_mag_reg;
            r2_a13_reg  <= r1_a13_reg;
            r2_neg_reg  <= r1_neg_reg;
            r2_held_reg <= held;
            r2_mode_reg <= r1_mode_reg;
        end
    end

    // Stage r3: scale speed and angle to drive units.
    logic                r3_valid_reg;
    logic [MW+23:0]      r3_spd_reg;
    logic signed [42:0]  r3_st_reg;
    logic                r3_neg_reg;
    logic                r3_held_reg;
    mode_t               r3_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r3_valid_reg <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r3_spd_reg  <= (MW+24)'(r2_mag_reg) * (MW+24)'(cfg.speed_scale);
            r3_st_reg   <= 43'(r2_a13_reg) * 43'($signed({1'b0, cfg.angle_scale}));
            r3_neg_reg  <= r2_neg_reg;
            r3_held_reg <= r2_held_reg;
            r3_mode_reg <= r2_mode_reg;
        end
    end

    // Output stage: round both products and apply the speed sign.
    logic [MW+23:0]     spd_rnd;
    logic [MW-9:0]      spd_mag;
    logic [42:0]        st_abs;
    logic [42:0]        st_rnd;
    logic [29:0]        st_mag;
    logic signed [31:0] speed_next;
    logic signed [31:0] steer_next;

    assign spd_rnd    = r3_spd_reg + ((MW+24)'(1) << 31);
    assign spd_mag    = spd_rnd[MW+23:32];
    assign speed_next = r3_neg_reg ? -$signed(32'(spd_mag)) : $signed(32'(spd_mag));
    assign st_abs     = r3_st_reg[42] ? 43'(-r3_st_reg) : 43'(r3_st_reg);
    assign st_rnd     = st_abs + 43'd4096;
    assign st_mag     = st_rnd[42:13];
    assign steer_next = r3_st_reg[42] ? -$signed(32'(st_mag)) : $signed(32'(st_mag));

    logic               res_valid_reg;
    logic signed [31:0] res_speed_reg;
    logic signed [31:0] res_steer_reg;
    logic               res_held_reg;
    mode_t              res_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= r3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_speed_reg <= speed_next;
            res_steer_reg <= steer_next;
            res_held_reg  <= r3_held_reg;
            res_mode_reg  <= r3_mode_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign speed_command = res_speed_reg;
    assign steer_command = res_steer_reg;
    assign speed_held    = res_held_reg;
    assign drive_mode    = res_mode_reg;

    // Checks on the result datapath and the input register.
    `include "steer_wheel_inverse_kinematics_assert.svh"

    `SWIK_ASSERT_NOW(a_stop_is_zero, res_valid_reg && res_mode_reg == MODE_STOP, res_speed_reg == '0 && res_steer_reg == '0 && !res_held_reg, "stop result not zero")
    `SWIK_ASSERT_NOW(a_held_no_speed, res_valid_reg && res_held_reg, res_speed_reg == '0, "held result with speed")
    `SWIK_ASSERT_NEXT(a_accept_loads, cmd_valid && !cmd_stall, p0_valid_reg, "accepted request not registered")

endmodule

`default_nettype wire
